// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent checks sampled on i_clk, masked while i_rst_n is low.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/tsnm_pkg.sv =====
`default_nettype none
package tsnm_pkg;
    localparam int FRAC_BITS_DEF = 14;
    localparam int UNIT_FRAC     = 30;             // unit vectors are Q30
    localparam int COMP_W        = 16;             // N, T and result components
    localparam int TEX_W         = 8;
    localparam int TX_W          = TEX_W + 1;      // signed texel - 128
    localparam int CROSS_W       = 2 * COMP_W + 1; // exact N x T component
    localparam int MAG_W         = UNIT_FRAC + 1;  // normalized magnitude
    localparam int SUM_W         = 64;             // sum of squares, remainders
    localparam int ROOT_W        = SUM_W / 2;
    localparam int QUO_W         = UNIT_FRAC + 1;
    localparam int UNIT_W        = 32;             // signed Q30 unit component
    localparam int OUT_MAX       = 32767;
    localparam int NORM_LSB      = 0;
    localparam int TANG_LSB      = 3 * COMP_W;
    localparam int TEX_LSB       = 6 * COMP_W;
    localparam int IN_DATA_W     = 6 * COMP_W + 3 * TEX_W;
    localparam int OUT_DATA_W    = 3 * COMP_W;

    typedef logic [2:0][COMP_W-1:0] t_vec16;
    typedef logic [2:0][TEX_W-1:0]  t_texel;
    typedef logic [2:0][UNIT_W-1:0] t_unit;
    typedef logic [2:0][MAG_W-1:0]  t_mag;
endpackage
`default_nettype wire

// ===== rtl/tsnm_sqrt.sv =====
`default_nettype none
module tsnm_sqrt
    import tsnm_pkg::*;
#(
    parameter int SW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [SUM_W-1:0]  i_s,
    input  wire logic [SW-1:0]     i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output logic [SW-1:0]          o_side
);
    // one root bit per stage, remainder kept as s - root^2
    logic [SUM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    logic              r_v    [ROOT_W+1];
    logic [SW-1:0]     r_side [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_s;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 1; j <= ROOT_W; j++) begin : g_step
        localparam int BIT = ROOT_W - j;
        logic [SUM_W-1:0] trial;

        assign trial = (SUM_W'(r_root[j-1]) << (BIT + 1)) | (SUM_W'(1) << (2 * BIT));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= r_side[j-1];
                if (r_rem[j-1] >= trial) begin
                    r_rem[j]  <= r_rem[j-1] - trial;
                    r_root[j] <= r_root[j-1] | (ROOT_W'(1) << BIT);
                end else begin
                    r_rem[j]  <= r_rem[j-1];
                    r_root[j] <= r_root[j-1];
                end
            end
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];
endmodule
`default_nettype wire

// ===== rtl/tsnm_div.sv =====
`default_nettype none
module tsnm_div
    import tsnm_pkg::*;
#(
    parameter int SW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_mag              i_mag,
    input  wire logic [ROOT_W-1:0] i_len,
    input  wire logic [SW-1:0]     i_side,
    output logic                   o_valid,
    output logic [2:0][QUO_W-1:0]  o_quo,
    output logic [SW-1:0]          o_side
);
    // q = (mag * 2^31 + len) / (2 * len), restoring, one quotient bit per stage
    logic [2:0][SUM_W-1:0] r_rem  [QUO_W+1];
    logic [2:0][QUO_W-1:0] r_q    [QUO_W+1];
    logic [ROOT_W:0]       r_d    [QUO_W+1];
    logic                  r_v    [QUO_W+1];
    logic [SW-1:0]         r_side [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= (SUM_W'(i_mag[k]) << (UNIT_FRAC + 1)) + SUM_W'(i_len);
            end
            r_q[0]    <= '0;
            r_d[0]    <= {i_len, 1'b0};
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_step
        localparam int BIT = QUO_W - j;
        logic [SUM_W-1:0] trial;

        assign trial = SUM_W'(r_d[j-1]) << BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[j]    <= r_d[j-1];
                r_side[j] <= r_side[j-1];
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[j-1][k] >= trial) begin
                        r_rem[j][k] <= r_rem[j-1][k] - trial;
                        r_q[j][k]   <= r_q[j-1][k] | (QUO_W'(1) << BIT);
                    end else begin
                        r_rem[j][k] <= r_rem[j-1][k];
                        r_q[j][k]   <= r_q[j-1][k];
                    end
                end
            end
        end
    end

    assign o_valid = r_v[QUO_W];
    assign o_quo   = r_q[QUO_W];
    assign o_side  = r_side[QUO_W];
endmodule
`default_nettype wire

// ===== rtl/tsnm_unit.sv =====
`default_nettype none
module tsnm_unit
    import tsnm_pkg::*;
#(
    parameter int W  = CROSS_W,
    parameter int SW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [2:0][W-1:0] i_vec,
    input  wire logic [SW-1:0]     i_side,
    output logic                   o_valid,
    output t_unit                  o_unit,
    output logic                   o_degen,
    output logic [SW-1:0]          o_side
);
    localparam int EW = $clog2(W);
    localparam int CW = SW + 1 + 3 + 3 * MAG_W;
    localparam int DW = SW + 1 + 3;

    // stage 1: sign and magnitude
    logic [2:0][W-1:0] r_mag1;
    logic [2:0]        r_neg1;
    logic              r_v1;
    logic [SW-1:0]     r_side1;
    // stage 2: leading one of the largest magnitude
    logic [2:0][W-1:0] r_mag2;
    logic [2:0]        r_neg2;
    logic              r_zero2;
    logic [EW-1:0]     r_msb2;
    logic              r_v2;
    logic [SW-1:0]     r_side2;
    // stage 3: common shift to put the largest in [2^30, 2^31)
    t_mag              r_mag3;
    logic [2:0]        r_neg3;
    logic              r_zero3;
    logic              r_v3;
    logic [SW-1:0]     r_side3;
    // stage 4: squares
    logic [2:0][2*MAG_W-1:0] r_sq4;
    t_mag              r_mag4;
    logic [2:0]        r_neg4;
    logic              r_zero4;
    logic              r_v4;
    logic [SW-1:0]     r_side4;
    // stage 5: sum of squares
    logic [SUM_W-1:0]  r_s5;
    t_mag              r_mag5;
    logic [2:0]        r_neg5;
    logic              r_zero5;
    logic              r_v5;
    logic [SW-1:0]     r_side5;
    // result stage
    t_unit             r_unit;
    logic              r_degen;
    logic              r_vo;
    logic [SW-1:0]     r_sideo;

    logic [W-1:0]      mag_or;
    logic [EW-1:0]     msb;
    t_mag              n_mag3;

    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    logic [CW-1:0]     sq_side;
    logic [SW-1:0]     s_side;
    logic              s_zero;
    logic [2:0]        s_neg;
    t_mag              s_mag;

    logic                  dv_v;
    logic [2:0][QUO_W-1:0] dv_quo;
    logic [DW-1:0]         dv_side;
    logic [SW-1:0]         d_side;
    logic                  d_zero;
    logic [2:0]            d_neg;

    always_comb begin
        mag_or = r_mag1[0] | r_mag1[1] | r_mag1[2];
        msb    = '0;
        for (int k = 0; k < W; k++) begin
            if (mag_or[k]) begin
                msb = EW'(k);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_msb2 > EW'(UNIT_FRAC)) begin
                n_mag3[k] = MAG_W'(r_mag2[k] >> (r_msb2 - EW'(UNIT_FRAC)));
            end else begin
                n_mag3[k] = MAG_W'(r_mag2[k] << (EW'(UNIT_FRAC) - r_msb2));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_vo <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_neg1[k] <= i_vec[k][W-1];
                r_mag1[k] <= i_vec[k][W-1] ? (~i_vec[k] + W'(1)) : i_vec[k];
                r_sq4[k]  <= (2*MAG_W)'(r_mag3[k]) * (2*MAG_W)'(r_mag3[k]);
            end
            r_side1 <= i_side;

            r_mag2  <= r_mag1;
            r_neg2  <= r_neg1;
            r_zero2 <= (mag_or == '0);
            r_msb2  <= msb;
            r_side2 <= r_side1;

            r_mag3  <= n_mag3;
            r_neg3  <= r_neg2;
            r_zero3 <= r_zero2;
            r_side3 <= r_side2;

            r_mag4  <= r_mag3;
            r_neg4  <= r_neg3;
            r_zero4 <= r_zero3;
            r_side4 <= r_side3;

            r_s5    <= SUM_W'(r_sq4[0]) + SUM_W'(r_sq4[1]) + SUM_W'(r_sq4[2]);
            r_mag5  <= r_mag4;
            r_neg5  <= r_neg4;
            r_zero5 <= r_zero4;
            r_side5 <= r_side4;
        end
    end

    tsnm_sqrt #(
        .SW(CW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v5),
        .i_s     (r_s5),
        .i_side  ({r_side5, r_zero5, r_neg5, r_mag5}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {s_side, s_zero, s_neg, s_mag} = sq_side;

    tsnm_div #(
        .SW(DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (sq_v),
        .i_mag   (s_mag),
        .i_len   (sq_root),
        .i_side  ({s_side, s_zero, s_neg}),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    assign {d_side, d_zero, d_neg} = dv_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                if (d_zero) begin
                    r_unit[k] <= '0;
                end else if (d_neg[k]) begin
                    r_unit[k] <= -UNIT_W'(dv_quo[k]);
                end else begin
                    r_unit[k] <= UNIT_W'(dv_quo[k]);
                end
            end
            r_degen <= d_zero;
            r_sideo <= d_side;
        end
    end

    assign o_valid = r_vo;
    assign o_unit  = r_unit;
    assign o_degen = r_degen;
    assign o_side  = r_sideo;
endmodule
`default_nettype wire

// ===== rtl/tsnm_perturb.sv =====
`default_nettype none
module tsnm_perturb
    import tsnm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int PW        = 49
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire t_vec16             i_normal,
    input  wire t_vec16             i_tangent,
    input  wire t_unit              i_unit,
    input  wire t_texel             i_texel,
    input  wire logic               i_degen,
    output logic                    o_valid,
    output logic [2:0][PW-1:0]      o_pert,
    output logic                    o_degen
);
    localparam int WSH = UNIT_FRAC - FRAC_BITS;

    // P = T*tx + B*ty + N*tz with B = -U, so the U term subtracts
    logic signed [TX_W-1:0]          tc [3];
    logic signed [COMP_W+TX_W-1:0]   r_tp [3];
    logic signed [UNIT_W+TX_W-1:0]   r_up [3];
    logic signed [COMP_W+TX_W-1:0]   r_np [3];
    logic [2:0][PW-1:0]              r_pert;
    logic                            r_v1;
    logic                            r_v2;
    logic                            r_dg1;
    logic                            r_dg2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tc[k] = $signed(TX_W'(i_texel[k]) - TX_W'(128));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_tp[k]   <= $signed(i_tangent[k]) * tc[0];
                r_up[k]   <= $signed(i_unit[k]) * tc[1];
                r_np[k]   <= $signed(i_normal[k]) * tc[2];
                r_pert[k] <= (PW'(r_tp[k]) <<< WSH) - PW'(r_up[k]) + (PW'(r_np[k]) <<< WSH);
            end
            r_dg1 <= i_degen;
            r_dg2 <= r_dg1;
        end
    end

    assign o_valid = r_v2;
    assign o_pert  = r_pert;
    assign o_degen = r_dg2;
endmodule
`default_nettype wire

// ===== rtl/tangent_space_normal_map.sv =====
// Throughput: one request per cycle, sustained, limited by nothing but the
// output side; the input skid register holds one request during a stall.
// Reset: synchronous, active low; clears every valid bit and the skid flag,
// no data is held between requests so nothing else needs clearing.
`default_nettype none
`include "assert_macros.svh"
module tangent_space_normal_map
    import tsnm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
    // texel_red, texel_green, texel_blue
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // result_x, result_y, result_z
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    // degenerate
    output logic                       o_m_tuser
);
    // Datapath, all stages advance together on pipe_en:
    //   2  cross product (products, then differences)
    //  71  normalize N x T into the Q30 unit vector U (B = -U)
    //   2  perturbed normal P = T*tx - U*ty + N*tz
    //  71  normalize P
    //   1  round to Q1.FRAC_BITS, saturate, output register
    // Each normalize: abs, leading one, shift, squares, sum, 33-stage
    // square root, 32-stage divider, sign.
    localparam int WSH    = UNIT_FRAC - FRAC_BITS;
    localparam int PROD_W = COMP_W + TX_W + WSH;
    localparam int PW     = ((PROD_W > UNIT_W + TX_W) ? PROD_W : UNIT_W + TX_W) + 2;
    localparam logic [UNIT_W-1:0] RND = (WSH > 0) ? (UNIT_W'(1) << (WSH - 1)) : '0;

    // global stall: pipeline moves whenever the output register is empty or i_m_tready is high
    logic                  pipe_en;
    logic                  s_acc;
    logic                  src_v;
    logic [IN_DATA_W-1:0]  src_data;

    logic                  r_skid_full;
    logic [IN_DATA_W-1:0]  r_skid_data;

    logic [COMP_W-1:0]     nrm [3];
    logic [COMP_W-1:0]     tng [3];
    logic [2*COMP_W-1:0]   r_prod [6];
    logic [IN_DATA_W-1:0]  r_data1;
    logic                  r_v1;
    logic [2:0][CROSS_W-1:0] r_cross;
    logic [IN_DATA_W-1:0]  r_data2;
    logic                  r_v2;

    logic                  a_v;
    t_unit                 a_unit;
    logic                  a_degen;
    logic [IN_DATA_W-1:0]  a_data;

    logic                  p_v;
    logic [2:0][PW-1:0]    p_pert;
    logic                  p_degen;

    logic                  b_v;
    t_unit                 b_unit;
    logic                  b_degen;
    logic                  b_side;

    logic [UNIT_W-1:0]     mag [3];
    logic [UNIT_W-1:0]     rnd [3];
    logic [COMP_W-2:0]     sat [3];
    t_vec16                n_res;
    t_vec16                r_res;
    logic                  r_degen;
    logic                  r_out_v;

    assign pipe_en    = !r_out_v || i_m_tready;
    assign o_s_tready = !r_skid_full;
    assign s_acc      = i_s_tvalid && !r_skid_full;
    assign src_v      = r_skid_full || s_acc;
    assign src_data   = r_skid_full ? r_skid_data : i_s_tdata;

    // skid: a request that arrives while the pipeline is stalled waits here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (pipe_en) begin
            r_skid_full <= 1'b0;
        end else begin
            r_skid_full <= r_skid_full || s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!pipe_en && s_acc) begin
            r_skid_data <= i_s_tdata;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nrm[k] = src_data[NORM_LSB + COMP_W*k +: COMP_W];
            tng[k] = src_data[TANG_LSB + COMP_W*k +: COMP_W];
        end
    end

    // cross product N x T, exact
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (pipe_en) begin
            r_v1 <= src_v;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_prod[0] <= $signed(nrm[1]) * $signed(tng[2]);
            r_prod[1] <= $signed(nrm[2]) * $signed(tng[1]);
            r_prod[2] <= $signed(nrm[2]) * $signed(tng[0]);
            r_prod[3] <= $signed(nrm[0]) * $signed(tng[2]);
            r_prod[4] <= $signed(nrm[0]) * $signed(tng[1]);
            r_prod[5] <= $signed(nrm[1]) * $signed(tng[0]);
            r_data1   <= src_data;
            for (int k = 0; k < 3; k++) begin
                r_cross[k] <= CROSS_W'($signed(r_prod[2*k])) - CROSS_W'($signed(r_prod[2*k+1]));
            end
            r_data2 <= r_data1;
        end
    end

    tsnm_unit #(
        .W  (CROSS_W),
        .SW (IN_DATA_W)
    ) u_unit_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_v2),
        .i_vec   (r_cross),
        .i_side  (r_data2),
        .o_valid (a_v),
        .o_unit  (a_unit),
        .o_degen (a_degen),
        .o_side  (a_data)
    );

    tsnm_perturb #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (PW)
    ) u_perturb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (a_v),
        .i_normal  (a_data[NORM_LSB +: 3*COMP_W]),
        .i_tangent (a_data[TANG_LSB +: 3*COMP_W]),
        .i_unit    (a_unit),
        .i_texel   (a_data[TEX_LSB +: 3*TEX_W]),
        .i_degen   (a_degen),
        .o_valid   (p_v),
        .o_pert    (p_pert),
        .o_degen   (p_degen)
    );

    tsnm_unit #(
        .W  (PW),
        .SW (1)
    ) u_unit_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (p_v),
        .i_vec   (p_pert),
        .i_side  (p_degen),
        .o_valid (b_v),
        .o_unit  (b_unit),
        .o_degen (b_degen),
        .o_side  (b_side)
    );

    // Q30 -> Q1.FRAC_BITS: magnitude rounded half up, saturated, then signed
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = b_unit[k][UNIT_W-1] ? (~b_unit[k] + UNIT_W'(1)) : b_unit[k];
            rnd[k] = (mag[k] + RND) >> WSH;
            sat[k] = (rnd[k] > UNIT_W'(OUT_MAX)) ? (COMP_W-1)'(OUT_MAX) : rnd[k][COMP_W-2:0];
            if (b_degen || b_side) begin
                n_res[k] = '0;
            end else if (b_unit[k][UNIT_W-1]) begin
                n_res[k] = -{1'b0, sat[k]};
            end else begin
                n_res[k] = {1'b0, sat[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (pipe_en) begin
            r_out_v <= b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_res   <= n_res;
            r_degen <= b_degen || b_side;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_res;
    assign o_m_tuser  = r_degen;

    `ASSERT_NEXT(a_skid_drain, r_skid_full && pipe_en, !r_skid_full, "skid request not drained")
    `ASSERT_NEXT(a_skid_fill, s_acc && !pipe_en, r_skid_full, "stalled request dropped")
    `ASSERT_IMPLY(a_degen_zero, r_out_v && r_degen, r_res == '0, "degenerate result not zero")
endmodule
`default_nettype wire
